// File: hdl/fnvfd_pkg.sv
`timescale 1ns / 1ps
// fnvfd_pkg: constants, sequencer states and digest expansion for the fnv1a/fmix digest core
// used by fnv1a_fmix_digest_core and fnvfd_checker; no dependencies

package fnvfd_pkg;

    localparam logic [31:0] FNV_BASIS  = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;
    localparam logic [31:0] EMPTY_HASH = 32'hDEAD_BEEF;
    localparam logic [31:0] FMIX_C1    = 32'h85EB_CA6B;
    localparam logic [31:0] FMIX_C2    = 32'hC2B2_AE35;
    localparam logic [31:0] WORD0_KEY  = 32'h5A82_7999;
    localparam logic [31:0] WORD1_KEY  = 32'h6ED9_EBA1;
    localparam logic [31:0] WORD2_KEY  = 32'h8F1B_BCDC;
    localparam logic [31:0] WORD3_KEY  = 32'hCA62_C1D6;

    localparam int unsigned OUT_DATA_W = 224;

    // sequencer states of the shared multiplier
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_MIX1,
        ST_MIX2,
        ST_DONE
    } fnvfd_state_t;

    // expanded digest words
    typedef struct packed {
        logic [59:0] short_digest;
        logic [31:0] word3;
        logic [31:0] word2;
        logic [31:0] word1;
        logic [31:0] word0;
        logic [31:0] hash;
    } fnvfd_digest_t;

    function automatic fnvfd_digest_t fnvfd_expand(input logic [31:0] h);
        fnvfd_digest_t d;
        d.hash         = h;
        d.word0        = h ^ WORD0_KEY;
        d.word1        = {h[18:0], h[31:19]} ^ WORD1_KEY;
        d.word2        = ~h ^ WORD2_KEY;
        d.word3        = {h[14:0], h[31:15]} ^ WORD3_KEY;
        d.short_digest = {d.word0, d.word1[31:4]};
        return d;
    endfunction

endpackage

// File: hdl/fnv1a_fmix_digest_core.sv
`timescale 1ns / 1ps
// fnv1a_fmix_digest_core: byte-serial fnv-1a hash (byte sign-extended before the xor) with murmur3 fmix32 finalizer
// and four-word digest expansion; depends on fnvfd_pkg
//
//  channel | dir | tdata                              | tuser          | tlast
//  s_axis  | in  | byte_value[7:0]                    | empty_message  | last_byte
//  m_axis  | out | hash, word0..word3, short_digest   | -              | -
//
// one 32x32 multiplier (low half) is shared by the fnv step and both fmix multiplies.
// ordinary byte: accept, prime multiply; last byte: accept, prime, fmix c1, fmix c2,
// load output; empty message: accept, load output.
// the output register holds a finished digest while the next bytes are hashed; the
// sequencer waits in its load step only while that register is still full and stalled.
// reset is asynchronous, active low; the running hash returns to the offset basis.

module fnv1a_fmix_digest_core
    import fnvfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] byte_value
    input  logic         s_tlast,   // last_byte
    input  logic         s_tuser,   // [0] empty_message
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] mixed_hash, [63:32] digest_word0, [95:64] digest_word1,
    // [127:96] digest_word2, [159:128] digest_word3, [219:160] short_digest, [223:220] zero
    output logic [OUT_DATA_W-1:0] m_tdata
);

    fnvfd_state_t state_reg, state_next;

    logic [31:0] hash_reg, hash_next;
    logic [31:0] work_reg, work_next;
    logic        fin_reg,  fin_next;
    logic [31:0] out_hash_reg, out_hash_next;
    logic        out_valid_reg, out_valid_next;

    // captured last flag for the prime step
    logic        s_tlast_reg, s_tlast_next;

    logic        in_beat;
    logic        out_free;
    logic [31:0] mul_a, mul_b, mul_prod;
    logic [31:0] final_hash;
    fnvfd_digest_t digest;

    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = work_reg;
        mul_b = FNV_PRIME;
        unique case (state_reg)
            ST_MIX1:
            begin
                mul_a = work_reg ^ {16'd0, work_reg[31:16]};
                mul_b = FMIX_C1;
            end
            ST_MIX2:
            begin
                mul_a = work_reg ^ {13'd0, work_reg[31:13]};
                mul_b = FMIX_C2;
            end
            default:
            begin
                mul_a = work_reg;
                mul_b = FNV_PRIME;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // last fmix xor-shift, skipped for the empty-message constant
    assign final_hash = fin_reg ? (work_reg ^ {16'd0, work_reg[31:16]}) : work_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                    state_next = s_tuser ? ST_DONE : ST_PRIME;
            end
            ST_PRIME:
                state_next = s_tlast_reg ? ST_MIX1 : ST_IDLE;
            ST_MIX1:
                state_next = ST_MIX2;
            ST_MIX2:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and output register updates
    always_comb
    begin
        hash_next      = hash_reg;
        work_next      = work_reg;
        fin_next       = fin_reg;
        s_tlast_next   = s_tlast_reg;
        out_hash_next  = out_hash_reg;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (in_beat)
                begin
                    s_tlast_next = s_tlast;
                    if (s_tuser)
                    begin
                        hash_next = FNV_BASIS;
                        work_next = EMPTY_HASH;
                        fin_next  = 1'b0;
                    end
                    else
                    begin
                        work_next = hash_reg ^ {{24{s_tdata[7]}}, s_tdata};
                    end
                end
            end
            ST_PRIME:
            begin
                if (s_tlast_reg)
                begin
                    hash_next = FNV_BASIS;
                    work_next = mul_prod;
                    fin_next  = 1'b1;
                end
                else
                begin
                    hash_next = mul_prod;
                end
            end
            ST_MIX1, ST_MIX2:
                work_next = mul_prod;
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_hash_next  = final_hash;
                    out_valid_next = 1'b1;
                end
            end
            default:
                s_tready = 1'b0;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hash_reg      <= FNV_BASIS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        fin_reg      <= fin_next;
        s_tlast_reg  <= s_tlast_next;
        out_hash_reg <= out_hash_next;
    end

    // digest expansion from the held hash
    assign digest   = fnvfd_expand(out_hash_reg);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, digest};

endmodule

// File: hdl/fnvfd_checker.sv
`timescale 1ns / 1ps
// fnvfd_checker: port-level assertions for fnv1a_fmix_digest_core, bound into fnv1a_fmix_digest_core
// depends on fnvfd_pkg

module fnvfd_checker
    import fnvfd_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [223:0] m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // every byte beat keeps the core busy in the following cycle
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // word0, word2, the short digest and the zero pad follow from the hash field
    a_words_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[63:32] == (m_tdata[31:0] ^ WORD0_KEY))
                  && (m_tdata[127:96] == (~m_tdata[31:0] ^ WORD2_KEY))
                  && (m_tdata[219:160] == {m_tdata[63:32], m_tdata[95:68]})
                  && (m_tdata[223:220] == 4'd0))
        else $error("digest words inconsistent with hash");

    // an empty message with a free output yields the fixed hash via the done state and the output register
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser && (!m_tvalid || m_tready)
            |=> ##1 (m_tvalid && (m_tdata[31:0] == EMPTY_HASH)))
        else $error("empty message did not produce fixed hash");

endmodule

bind fnv1a_fmix_digest_core fnvfd_checker u_fnvfd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
